// ----- rtl/table_driven_turing_machine_top_assert.svh -----
// Assertion macros shared by the checker of the Turing machine block.
`ifndef TABLE_DRIVEN_TURING_MACHINE_TOP_ASSERT_SVH
`define TABLE_DRIVEN_TURING_MACHINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TTM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttm: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define TTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttm: next-cycle check failed");

`endif

// ----- rtl/ttm_pkg.sv -----
`default_nettype none

package ttm_pkg;

  // Machine dimensions.
  localparam int TAPE_CELLS   = 1024;
  localparam int STATE_COUNT  = 32;
  localparam int SYMBOL_COUNT = 16;
  localparam int RULE_ENTRIES = STATE_COUNT * SYMBOL_COUNT;
  localparam int TAPE_AW      = $clog2(TAPE_CELLS);
  localparam int RULE_AW      = $clog2(RULE_ENTRIES);

  // Field widths of the command and response transactions.
  localparam int OP_W     = 3;
  localparam int STATE_W  = 5;
  localparam int SYM_W    = 4;
  localparam int MOVE_W   = 2;
  localparam int HEAD_W   = 10;
  localparam int STEP_W   = 16;
  localparam int STATUS_W = 3;
  localparam int MASK_W   = 32;

  // Configuration port.
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FINAL_MASK = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_HEAD = 2'd2;

  localparam logic [MASK_W-1:0] FINAL_MASK_RESET = '0;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 16'd10001;
  localparam logic [HEAD_W-1:0] START_HEAD_RESET = 10'd1;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_LOAD_RULE  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_TAPE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_TAPE  = 3'd2;
  localparam logic [OP_W-1:0] OP_START      = 3'd3;
  localparam logic [OP_W-1:0] OP_STEP       = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FINAL    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NO_RULE  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_LIMIT    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_OFF_TAPE = 3'd4;

  // Head moves.
  localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd2;

  localparam logic [SYM_W-1:0]   BLANK_SYM   = 4'd10;
  localparam logic [STATE_W-1:0] START_STATE = 5'd1;
  localparam logic [HEAD_W-1:0]  HEAD_RESET  = 10'd1;

  // Configuration register file contents.
  typedef struct packed {
    logic [MASK_W-1:0] final_mask;
    logic [STEP_W-1:0] step_limit;
    logic [HEAD_W-1:0] start_head;
  } cfg_t;

  // One rule table entry.
  typedef struct packed {
    logic               valid;
    logic [SYM_W-1:0]   write_sym;
    logic [MOVE_W-1:0]  move;
    logic [STATE_W-1:0] next_state;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Memory access requests from the sequencer.
  typedef struct packed {
    logic               we;
    logic [TAPE_AW-1:0] waddr;
    logic [SYM_W-1:0]   wdata;
    logic               re;
    logic [TAPE_AW-1:0] raddr;
  } tape_req_t;

  typedef struct packed {
    logic               we;
    logic [RULE_AW-1:0] waddr;
    rule_t              wdata;
    logic               re;
    logic [RULE_AW-1:0] raddr;
  } rule_req_t;

endpackage

`default_nettype wire

// ----- rtl/ttm_cmd_if.sv -----
`default_nettype none

interface ttm_cmd_if;
  import ttm_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [STATE_W-1:0] rule_state;
  logic [SYM_W-1:0]   symbol;
  logic               rule_defined;
  logic [SYM_W-1:0]   rule_write_symbol;
  logic [MOVE_W-1:0]  rule_move;
  logic [STATE_W-1:0] rule_next_state;
  logic [HEAD_W-1:0]  tape_address;

  modport source (
    output valid, opcode, rule_state, symbol, rule_defined,
    output rule_write_symbol, rule_move, rule_next_state, tape_address,
    input  ready
  );

  modport sink (
    input  valid, opcode, rule_state, symbol, rule_defined,
    input  rule_write_symbol, rule_move, rule_next_state, tape_address,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ttm_rsp_if.sv -----
`default_nettype none

interface ttm_rsp_if;
  import ttm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STATE_W-1:0]  machine_state;
  logic [HEAD_W-1:0]   head_position;
  logic [SYM_W-1:0]    cell_symbol;
  logic [STEP_W-1:0]   steps_taken;

  modport source (
    output valid, status, machine_state, head_position, cell_symbol, steps_taken,
    input  ready
  );

  modport sink (
    input  valid, status, machine_state, head_position, cell_symbol, steps_taken,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ttm_ram.sv -----
`default_nettype none

module ttm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ttm_regs.sv -----
`default_nettype none

module ttm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttm_pkg::APB_AW-1:0] paddr,
  input  logic [ttm_pkg::APB_DW-1:0] pwdata,
  output logic [ttm_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ttm_pkg::cfg_t              cfg_o
);
  import ttm_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register write decode; addresses beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_FINAL_MASK: cfg_d.final_mask = pwdata[MASK_W-1:0];
        REG_STEP_LIMIT: cfg_d.step_limit = pwdata[STEP_W-1:0];
        REG_START_HEAD: cfg_d.start_head = pwdata[HEAD_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_FINAL_MASK: prdata = APB_DW'(cfg_q.final_mask);
      REG_STEP_LIMIT: prdata = APB_DW'(cfg_q.step_limit);
      REG_START_HEAD: prdata = APB_DW'(cfg_q.start_head);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.final_mask <= FINAL_MASK_RESET;
      cfg_q.step_limit <= STEP_LIMIT_RESET;
      cfg_q.start_head <= START_HEAD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ttm_ctrl.sv -----
`default_nettype none

module ttm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ttm_cmd_if.sink                      cmd_i,
  ttm_rsp_if.source                    rsp_o,
  input  ttm_pkg::cfg_t                cfg_i,
  output ttm_pkg::tape_req_t           tape_req_o,
  input  logic [ttm_pkg::SYM_W-1:0]    tape_rdata_i,
  output ttm_pkg::rule_req_t           rule_req_o,
  input  ttm_pkg::rule_t               rule_rdata_i
);
  import ttm_pkg::*;

  localparam int CLEAR_COUNT = (TAPE_CELLS > RULE_ENTRIES) ? TAPE_CELLS : RULE_ENTRIES;
  localparam int CLR_W       = $clog2(CLEAR_COUNT);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_TAPE  = 5'b01000,
    S_RULE  = 5'b10000
  } fsm_e;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [STATE_W-1:0] rule_state;
    logic [SYM_W-1:0]   symbol;
    logic               rule_defined;
    logic [SYM_W-1:0]   rule_write_symbol;
    logic [MOVE_W-1:0]  rule_move;
    logic [STATE_W-1:0] rule_next_state;
    logic [HEAD_W-1:0]  tape_address;
  } cmd_t;

  fsm_e                state_q, state_d;
  logic [CLR_W-1:0]    clr_q, clr_d;
  cmd_t                cmd_q, cmd_d;
  logic [STATE_W-1:0]  cur_q, cur_d;
  logic [HEAD_W-1:0]   head_q, head_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic                running_q, running_d;
  logic [STATUS_W-1:0] stop_q, stop_d;
  logic [SYM_W-1:0]    rsym_q, rsym_d;
  logic                miss_q, miss_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [STATE_W-1:0]  rsp_state_q, rsp_state_d;
  logic [HEAD_W-1:0]   rsp_head_q, rsp_head_d;
  logic [SYM_W-1:0]    rsp_cell_q, rsp_cell_d;
  logic [STEP_W-1:0]   rsp_steps_q, rsp_steps_d;

  logic                out_free;
  logic                load_out;
  logic [SYM_W-1:0]    cell_c;
  logic [HEAD_W-1:0]   start_pos;
  logic                off_tape;
  logic                next_final;
  logic [STEP_W-1:0]   steps_inc;

  // Flat rule table address of a (state, symbol) pair.
  function automatic logic [RULE_AW-1:0] rule_addr(input logic [STATE_W-1:0] s,
                                                   input logic [SYM_W-1:0] y);
    logic [31:0] full;
    full = 32'(s) * 32'(SYMBOL_COUNT) + 32'(y);
    return full[RULE_AW-1:0];
  endfunction

  function automatic logic key_in_range(input logic [STATE_W-1:0] s,
                                        input logic [SYM_W-1:0] y);
    return (32'(s) < STATE_COUNT) && (32'(y) < SYMBOL_COUNT);
  endfunction

  // The output register is free when empty or being drained this cycle.
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign start_pos = (32'(cfg_i.start_head) < TAPE_CELLS) ?
                     cfg_i.start_head : HEAD_W'(TAPE_CELLS - 1);
  assign off_tape  = ((rule_rdata_i.move == MOVE_RIGHT) &&
                      (32'(head_q) + 32'd1 >= TAPE_CELLS)) ||
                     ((rule_rdata_i.move == MOVE_LEFT) && (head_q == '0));
  assign next_final = (32'(rule_rdata_i.next_state) < MASK_W) &&
                      cfg_i.final_mask[rule_rdata_i.next_state];
  assign steps_inc  = steps_q + STEP_W'(1);

  assign cmd_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.machine_state = rsp_state_q;
  assign rsp_o.head_position = rsp_head_q;
  assign rsp_o.cell_symbol   = rsp_cell_q;
  assign rsp_o.steps_taken   = rsp_steps_q;

  // Sequencer: a step reads tape, then rule table, then writes back.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    cur_d      = cur_q;
    head_d     = head_q;
    steps_d    = steps_q;
    running_d  = running_q;
    stop_d     = stop_q;
    rsym_d     = rsym_q;
    miss_d     = miss_q;
    tape_req_o = '0;
    rule_req_o = '0;
    load_out   = 1'b0;
    cell_c     = '0;

    case (state_q)
      // Sweep both memories to their reset contents.
      S_CLEAR: begin
        tape_req_o.we    = (32'(clr_q) < TAPE_CELLS);
        tape_req_o.waddr = clr_q[TAPE_AW-1:0];
        tape_req_o.wdata = BLANK_SYM;
        rule_req_o.we    = (32'(clr_q) < RULE_ENTRIES);
        rule_req_o.waddr = clr_q[RULE_AW-1:0];
        rule_req_o.wdata = '0;
        if (clr_q == CLR_W'(CLEAR_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + CLR_W'(1);
        end
      end

      // Take a command and start a tape read for it.
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d.opcode            = cmd_i.opcode;
          cmd_d.rule_state        = cmd_i.rule_state;
          cmd_d.symbol            = cmd_i.symbol;
          cmd_d.rule_defined      = cmd_i.rule_defined;
          cmd_d.rule_write_symbol = cmd_i.rule_write_symbol;
          cmd_d.rule_move         = cmd_i.rule_move;
          cmd_d.rule_next_state   = cmd_i.rule_next_state;
          cmd_d.tape_address      = cmd_i.tape_address;
          tape_req_o.re           = 1'b1;
          case (cmd_i.opcode)
            OP_READ_TAPE: tape_req_o.raddr = cmd_i.tape_address[TAPE_AW-1:0];
            OP_START:     tape_req_o.raddr = start_pos[TAPE_AW-1:0];
            default:      tape_req_o.raddr = head_q[TAPE_AW-1:0];
          endcase
          if (cmd_i.opcode inside {OP_READ_TAPE, OP_START, OP_STEP}) begin
            state_d = S_TAPE;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      // Commands that need no tape read data.
      S_EXEC: begin
        if (out_free) begin
          case (cmd_q.opcode)
            OP_LOAD_RULE: begin
              if (key_in_range(cmd_q.rule_state, cmd_q.symbol)) begin
                rule_req_o.we    = 1'b1;
                rule_req_o.waddr = rule_addr(cmd_q.rule_state, cmd_q.symbol);
                if (cmd_q.rule_defined) begin
                  rule_req_o.wdata.valid      = 1'b1;
                  rule_req_o.wdata.write_sym  = cmd_q.rule_write_symbol;
                  rule_req_o.wdata.move       = cmd_q.rule_move;
                  rule_req_o.wdata.next_state = cmd_q.rule_next_state;
                end
              end
            end
            OP_WRITE_TAPE: begin
              tape_req_o.we    = (32'(cmd_q.tape_address) < TAPE_CELLS);
              tape_req_o.waddr = cmd_q.tape_address[TAPE_AW-1:0];
              tape_req_o.wdata = cmd_q.symbol;
              cell_c           = cmd_q.symbol;
            end
            default: cell_c = '0;
          endcase
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Tape data is here.
      S_TAPE: begin
        case (cmd_q.opcode)
          OP_READ_TAPE: begin
            if (out_free) begin
              cell_c   = (32'(cmd_q.tape_address) < TAPE_CELLS) ? tape_rdata_i : BLANK_SYM;
              load_out = 1'b1;
              state_d  = S_IDLE;
            end
          end
          OP_START: begin
            if (out_free) begin
              running_d = 1'b1;
              stop_d    = STS_OK;
              cur_d     = START_STATE;
              head_d    = start_pos;
              steps_d   = '0;
              cell_c    = tape_rdata_i;
              load_out  = 1'b1;
              state_d   = S_IDLE;
            end
          end
          OP_STEP: begin
            if (!running_q || (steps_q >= cfg_i.step_limit)) begin
              if (out_free) begin
                if (running_q) begin
                  running_d = 1'b0;
                  stop_d    = STS_LIMIT;
                end
                cell_c   = tape_rdata_i;
                load_out = 1'b1;
                state_d  = S_IDLE;
              end
            end else begin
              rsym_d           = tape_rdata_i;
              miss_d           = !key_in_range(cur_q, tape_rdata_i);
              rule_req_o.re    = 1'b1;
              rule_req_o.raddr = rule_addr(cur_q, tape_rdata_i);
              state_d          = S_RULE;
            end
          end
          default: begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end
        endcase
      end

      // Rule entry is here: apply it or stop the run.
      S_RULE: begin
        if (out_free) begin
          if (miss_q || !rule_rdata_i.valid) begin
            running_d = 1'b0;
            stop_d    = STS_NO_RULE;
            cell_c    = rsym_q;
          end else if (off_tape) begin
            running_d = 1'b0;
            stop_d    = STS_OFF_TAPE;
            cell_c    = rsym_q;
          end else begin
            tape_req_o.we    = 1'b1;
            tape_req_o.waddr = head_q[TAPE_AW-1:0];
            tape_req_o.wdata = rule_rdata_i.write_sym;
            cur_d            = rule_rdata_i.next_state;
            if (rule_rdata_i.move == MOVE_RIGHT) begin
              head_d = head_q + HEAD_W'(1);
            end else if (rule_rdata_i.move == MOVE_LEFT) begin
              head_d = head_q - HEAD_W'(1);
            end
            steps_d = steps_inc;
            if (next_final) begin
              running_d = 1'b0;
              stop_d    = STS_FINAL;
            end else if (steps_inc >= cfg_i.step_limit) begin
              running_d = 1'b0;
              stop_d    = STS_LIMIT;
            end
            cell_c = rule_rdata_i.write_sym;
          end
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register: holds a response until it is taken.
  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_state_d  = rsp_state_q;
    rsp_head_d   = rsp_head_q;
    rsp_cell_d   = rsp_cell_q;
    rsp_steps_d  = rsp_steps_q;
    if (load_out) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = stop_d;
      rsp_state_d  = cur_d;
      rsp_head_d   = head_d;
      rsp_cell_d   = cell_c;
      rsp_steps_d  = steps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= START_STATE;
      head_q      <= HEAD_RESET;
      steps_q     <= '0;
      running_q   <= 1'b0;
      stop_q      <= STS_OK;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      head_q      <= head_d;
      steps_q     <= steps_d;
      running_q   <= running_d;
      stop_q      <= stop_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rsym_q       <= rsym_d;
    miss_q       <= miss_d;
    rsp_status_q <= rsp_status_d;
    rsp_state_q  <= rsp_state_d;
    rsp_head_q   <= rsp_head_d;
    rsp_cell_q   <= rsp_cell_d;
    rsp_steps_q  <= rsp_steps_d;
  end

endmodule

`default_nettype wire

// ----- rtl/table_driven_turing_machine_top.sv -----
// One-tape Turing machine with a 32-state by 16-symbol rule table and a 1024-cell tape,
// both held in single-port-read synchronous RAMs. After reset the block sweeps the tape
// to blank and the rule table to empty, and takes no command until that sweep ends;
// configuration writes are taken throughout. A command is taken when the sequencer is
// idle, also while the previous response still waits in the output register. Load rule,
// write tape, unknown opcodes, read tape, start and a step outside a run or at its limit
// register their response from the state that follows acceptance. A step inside a run
// passes through the tape read and then the dependent rule table read before the
// write-back registers its response. The next command is taken in the cycle after
// its predecessor's response is registered; a response that is not taken holds the
// block off until the output register has room.
`default_nettype none

module table_driven_turing_machine_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ttm_cmd_if.sink                    cmd_i,
  ttm_rsp_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttm_pkg::APB_AW-1:0] paddr,
  input  logic [ttm_pkg::APB_DW-1:0] pwdata,
  output logic [ttm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import ttm_pkg::*;

  cfg_t             cfg;
  tape_req_t        tape_req;
  rule_req_t        rule_req;
  logic [SYM_W-1:0] tape_rdata;
  rule_t            rule_rdata;

  // Configuration registers.
  ttm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Command sequencer.
  ttm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .rsp_o        (rsp_o),
    .cfg_i        (cfg),
    .tape_req_o   (tape_req),
    .tape_rdata_i (tape_rdata),
    .rule_req_o   (rule_req),
    .rule_rdata_i (rule_rdata)
  );

  // Tape storage.
  ttm_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_req.we),
    .waddr_i (tape_req.waddr),
    .wdata_i (tape_req.wdata),
    .re_i    (tape_req.re),
    .raddr_i (tape_req.raddr),
    .rdata_o (tape_rdata)
  );

  // Rule table storage.
  ttm_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_ENTRIES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_req.we),
    .waddr_i (rule_req.waddr),
    .wdata_i (rule_req.wdata),
    .re_i    (rule_req.re),
    .raddr_i (rule_req.raddr),
    .rdata_o (rule_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/ttm_checker.sv -----
`default_nettype none
`include "table_driven_turing_machine_top_assert.svh"

module ttm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ttm_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [ttm_pkg::STATE_W-1:0]   rsp_state_i,
  input logic [ttm_pkg::HEAD_W-1:0]    rsp_head_i,
  input logic [ttm_pkg::SYM_W-1:0]     rsp_cell_i,
  input logic [ttm_pkg::STEP_W-1:0]    rsp_steps_i
);
  import ttm_pkg::*;

  logic                                            cmd_xfer;
  logic                                            rsp_stall;
  logic [STATUS_W+STATE_W+HEAD_W+SYM_W+STEP_W-1:0] rsp_payload;

  assign cmd_xfer    = cmd_valid_i && cmd_ready_i;
  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_payload = {rsp_status_i, rsp_state_i, rsp_head_i, rsp_cell_i, rsp_steps_i};

  // A stalled response holds its payload.
  `TTM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_payload))

  // Only one command is in flight at a time.
  `TTM_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, cmd_xfer, !cmd_ready_i)

  // A response is not registered in the cycle that its command is taken, so an output register
  // that is empty or draining when a command is taken is empty in the next cycle.
  `TTM_ASSERT_NEXT(a_no_early_rsp, clk_i, rst_ni, cmd_xfer && !rsp_stall, !rsp_valid_i)

  // Status stays within its defined codes.
  `TTM_ASSERT_SAME(a_status_code, clk_i, rst_ni, rsp_valid_i, rsp_status_i <= STS_OFF_TAPE)

endmodule

bind table_driven_turing_machine_top ttm_checker u_ttm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_state_i  (rsp_o.machine_state),
  .rsp_head_i   (rsp_o.head_position),
  .rsp_cell_i   (rsp_o.cell_symbol),
  .rsp_steps_i  (rsp_o.steps_taken)
);

`default_nettype wire

// ----- test/ttm_test_pkg.sv -----
`timescale 1ns / 1ps

package ttm_test_pkg;
  import ttm_pkg::*;

  // Opcodes and a move code that carry no meaning for the block.
  localparam logic [OP_W-1:0]   OP_UNUSED_5   = 3'd5;
  localparam logic [OP_W-1:0]   OP_UNUSED_7   = 3'd7;
  localparam logic [MOVE_W-1:0] MOVE_RESERVED = 2'd3;

  // One command transaction as the testbench builds it.
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [STATE_W-1:0] rule_state;
    logic [SYM_W-1:0]   symbol;
    logic               rule_defined;
    logic [SYM_W-1:0]   rule_write_symbol;
    logic [MOVE_W-1:0]  rule_move;
    logic [STATE_W-1:0] rule_next_state;
    logic [HEAD_W-1:0]  tape_address;
  } machine_cmd_t;

  // One response transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STATE_W-1:0]  machine_state;
    logic [HEAD_W-1:0]   head_position;
    logic [SYM_W-1:0]    cell_symbol;
    logic [STEP_W-1:0]   steps_taken;
  } machine_rsp_t;

  // Mirror of the machine: tape, rules, registers and the responses still owed.
  class machine_mirror;
    logic [MASK_W-1:0]   final_mask;
    logic [STEP_W-1:0]   step_limit;
    logic [HEAD_W-1:0]   start_head;
    rule_t               rules [RULE_ENTRIES];
    logic [SYM_W-1:0]    tape [TAPE_CELLS];
    logic [STATE_W-1:0]  state;
    logic [HEAD_W-1:0]   head;
    logic [STEP_W-1:0]   steps;
    bit                  running;
    logic [STATUS_W-1:0] stop_code;
    machine_rsp_t        owed_rsp [$];
    int                  mismatches;
    int                  checked;
    int                  loads;
    int                  starts;
    int                  step_cmds;
    int                  step_outcome [8];

    function new();
      final_mask = FINAL_MASK_RESET;
      step_limit = STEP_LIMIT_RESET;
      start_head = START_HEAD_RESET;
      foreach (rules[i]) rules[i] = '0;
      foreach (tape[i]) tape[i] = BLANK_SYM;
      state = START_STATE;
      head = HEAD_RESET;
      steps = '0;
      running = 1'b0;
      stop_code = STS_OK;
      mismatches = 0;
      checked = 0;
      loads = 0;
      starts = 0;
      step_cmds = 0;
      foreach (step_outcome[i]) step_outcome[i] = 0;
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_FINAL_MASK: final_mask = value[MASK_W-1:0];
        REG_STEP_LIMIT: step_limit = value[STEP_W-1:0];
        REG_START_HEAD: start_head = value[HEAD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DW-1:0] register_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_FINAL_MASK: return APB_DW'(final_mask);
        REG_STEP_LIMIT: return APB_DW'(step_limit);
        REG_START_HEAD: return APB_DW'(start_head);
        default:        return '0;
      endcase
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    // One machine step inside a run; returns the symbol that the response reports.
    function logic [SYM_W-1:0] advance_machine();
      logic [SYM_W-1:0] under_head;
      rule_t            r;
      under_head = tape[head];
      // A limit that is already reached stops the run before anything moves.
      if (steps >= step_limit) begin
        running = 1'b0;
        stop_code = STS_LIMIT;
        return under_head;
      end
      r = rules[{state, under_head}];
      if (!r.valid) begin
        running = 1'b0;
        stop_code = STS_NO_RULE;
        return under_head;
      end
      // A move off either end leaves everything as it was.
      if ((r.move == MOVE_RIGHT && int'(head) == TAPE_CELLS - 1) ||
          (r.move == MOVE_LEFT && head == '0)) begin
        running = 1'b0;
        stop_code = STS_OFF_TAPE;
        return under_head;
      end
      tape[head] = r.write_sym;
      state = r.next_state;
      if (r.move == MOVE_RIGHT) begin
        head = head + 1'b1;
      end else if (r.move == MOVE_LEFT) begin
        head = head - 1'b1;
      end
      steps = steps + 1'b1;
      // A final state wins over a limit reached by the same step.
      if (final_mask[state]) begin
        running = 1'b0;
        stop_code = STS_FINAL;
      end else if (steps >= step_limit) begin
        running = 1'b0;
        stop_code = STS_LIMIT;
      end
      return r.write_sym;
    endfunction

    // Apply an accepted command and queue the response that it owes.
    function void take_command(machine_cmd_t c);
      logic [SYM_W-1:0] cell_sym;
      rule_t            r;
      machine_rsp_t     want;
      cell_sym = '0;
      case (c.opcode)
        OP_LOAD_RULE: begin
          r = '0;
          if (c.rule_defined) begin
            r.valid = 1'b1;
            r.write_sym = c.rule_write_symbol;
            r.move = c.rule_move;
            r.next_state = c.rule_next_state;
          end
          rules[{c.rule_state, c.symbol}] = r;
          loads++;
        end
        OP_WRITE_TAPE: begin
          tape[c.tape_address] = c.symbol;
          cell_sym = c.symbol;
        end
        OP_READ_TAPE: begin
          cell_sym = tape[c.tape_address];
        end
        OP_START: begin
          running = 1'b1;
          stop_code = STS_OK;
          state = START_STATE;
          head = start_head;
          steps = '0;
          cell_sym = tape[head];
          starts++;
        end
        OP_STEP: begin
          if (running) begin
            cell_sym = advance_machine();
          end else begin
            cell_sym = tape[head];
          end
          step_cmds++;
          step_outcome[stop_code]++;
        end
        default: ;
      endcase
      want.status = stop_code;
      want.machine_state = state;
      want.head_position = head;
      want.cell_symbol = cell_sym;
      want.steps_taken = steps;
      owed_rsp.push_back(want);
    endfunction

    task report_mismatch(string what, logic [APB_DW-1:0] got, logic [APB_DW-1:0] want);
      mismatches++;
      $display("mismatch on %s at response %0d: got 0x%0h, expected 0x%0h",
               what, checked, got, want);
    endtask

    // Compare one accepted response with the oldest owed one.
    task compare_response(machine_rsp_t got);
      machine_rsp_t want;
      if (owed_rsp.size() == 0) begin
        report_mismatch("response with no command waiting", APB_DW'(got), '0);
        return;
      end
      want = owed_rsp.pop_front();
      checked++;
      if (got.status !== want.status)
        report_mismatch("status", APB_DW'(got.status), APB_DW'(want.status));
      if (got.machine_state !== want.machine_state)
        report_mismatch("machine_state", APB_DW'(got.machine_state),
                        APB_DW'(want.machine_state));
      if (got.head_position !== want.head_position)
        report_mismatch("head_position", APB_DW'(got.head_position),
                        APB_DW'(want.head_position));
      if (got.cell_symbol !== want.cell_symbol)
        report_mismatch("cell_symbol", APB_DW'(got.cell_symbol), APB_DW'(want.cell_symbol));
      if (got.steps_taken !== want.steps_taken)
        report_mismatch("steps_taken", APB_DW'(got.steps_taken), APB_DW'(want.steps_taken));
    endtask
  endclass

endpackage

// ----- test/table_driven_turing_machine_top_test.sv -----
`timescale 1ns / 1ps

module table_driven_turing_machine_top_test;
  import ttm_pkg::*;
  import ttm_test_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_NS     = 3_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ttm_cmd_if cmd_if ();
  ttm_rsp_if rsp_if ();

  machine_mirror mirror;
  int            sent;
  int            reg_writes;
  int            random_base;
  int            src_idle_pct;
  int            rcv_idle_pct;
  bit            hold_req;

  table_driven_turing_machine_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Free-running clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // A command with every field random, the opcode over its whole width.
  function automatic machine_cmd_t random_cmd();
    machine_cmd_t c;
    c.opcode = OP_W'($urandom_range(7));
    c.rule_state = STATE_W'($urandom);
    c.symbol = SYM_W'($urandom);
    c.rule_defined = 1'($urandom);
    c.rule_write_symbol = SYM_W'($urandom);
    c.rule_move = MOVE_W'($urandom);
    c.rule_next_state = STATE_W'($urandom);
    c.tape_address = HEAD_W'($urandom);
    return c;
  endfunction

  // A tape cell a few places around the given one, kept on the tape.
  function automatic logic [HEAD_W-1:0] near_cell(int center);
    int a;
    a = center + int'($urandom_range(10)) - 3;
    if (a < 0) a = 0;
    if (a > TAPE_CELLS - 1) a = TAPE_CELLS - 1;
    return HEAD_W'(a);
  endfunction

  function automatic logic [MOVE_W-1:0] pick_move();
    int r;
    r = $urandom_range(99);
    if (r < 40) return MOVE_RIGHT;
    if (r < 80) return MOVE_LEFT;
    if (r < 95) return MOVE_STAY;
    return MOVE_RESERVED;
  endfunction

  function automatic logic [APB_DW-1:0] pick_mask();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return APB_DW'($urandom);
      default: return APB_DW'($urandom & $urandom);
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] pick_limit();
    case ($urandom_range(5))
      0: return 1;
      1: return 2;
      2: return $urandom_range(20, 3);
      3: return APB_DW'(STEP_LIMIT_RESET);
      4: return 65535;
      default: return $urandom_range(65535, 1);
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] pick_start_head();
    case ($urandom_range(4))
      0: return 0;
      1: return TAPE_CELLS - 1;
      2: return $urandom_range(8, 1);
      3: return $urandom_range(TAPE_CELLS - 2, TAPE_CELLS - 9);
      default: return $urandom_range(TAPE_CELLS - 1);
    endcase
  endfunction

  // Offer one command, idling first at random, and wait for its transaction.
  task automatic send(input machine_cmd_t c);
    if ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.opcode <= c.opcode;
    cmd_if.rule_state <= c.rule_state;
    cmd_if.symbol <= c.symbol;
    cmd_if.rule_defined <= c.rule_defined;
    cmd_if.rule_write_symbol <= c.rule_write_symbol;
    cmd_if.rule_move <= c.rule_move;
    cmd_if.rule_next_state <= c.rule_next_state;
    cmd_if.tape_address <= c.tape_address;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
    mirror.take_command(c);
    sent++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    machine_cmd_t c;
    c = random_cmd();
    c.opcode = op;
    send(c);
  endtask

  task automatic send_load(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sym,
                           input logic def, input logic [SYM_W-1:0] ws,
                           input logic [MOVE_W-1:0] mv, input logic [STATE_W-1:0] nx);
    machine_cmd_t c;
    c = random_cmd();
    c.opcode = OP_LOAD_RULE;
    c.rule_state = st;
    c.symbol = sym;
    c.rule_defined = def;
    c.rule_write_symbol = ws;
    c.rule_move = mv;
    c.rule_next_state = nx;
    send(c);
  endtask

  task automatic send_write(input logic [HEAD_W-1:0] addr, input logic [SYM_W-1:0] sym);
    machine_cmd_t c;
    c = random_cmd();
    c.opcode = OP_WRITE_TAPE;
    c.tape_address = addr;
    c.symbol = sym;
    send(c);
  endtask

  task automatic send_read(input logic [HEAD_W-1:0] addr);
    machine_cmd_t c;
    c = random_cmd();
    c.opcode = OP_READ_TAPE;
    c.tape_address = addr;
    send(c);
  endtask

  // Stop offering and wait until every owed response has arrived.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Register write followed by a read back; psel stays high between the two.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] seen;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    mirror.write_register(idx, value);
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    seen = prdata;
    if (seen !== mirror.register_value(idx))
      mirror.report_mismatch("register read back", seen, mirror.register_value(idx));
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Between phases: the block is idle, so registers may change.
  task automatic reconfigure();
    drain();
    if ($urandom_range(99) < 50) write_reg(REG_FINAL_MASK, pick_mask());
    if ($urandom_range(99) < 50) write_reg(REG_STEP_LIMIT, pick_limit());
    if ($urandom_range(99) < 50) write_reg(REG_START_HEAD, pick_start_head());
    apb_release();
  endtask

  // Corner cases of the machine, one by one.
  task automatic directed();
    // Blank tape, stopped machine, opcodes the block does not know, and writes at both ends.
    send_read('0);
    send_read(HEAD_W'(TAPE_CELLS - 1));
    send_op(OP_STEP);
    send_op(OP_UNUSED_5);
    send_op(OP_UNUSED_7);
    send_write('0, 4'd15);
    send_write(HEAD_W'(TAPE_CELLS - 1), 4'd0);
    send_read('0);

    // A run that writes and moves left, stays on the reserved move code, then finds no rule.
    send_load(START_STATE, BLANK_SYM, 1'b1, 4'd1, MOVE_LEFT, START_STATE);
    send_load(START_STATE, 4'd15, 1'b1, 4'd5, MOVE_RESERVED, 5'd31);
    send_op(OP_START);
    send_op(OP_STEP);
    send_op(OP_STEP);
    send_op(OP_STEP);
    send_op(OP_STEP);

    // Head at the last cell: a right move would leave the tape.
    drain();
    write_reg(REG_FINAL_MASK, '1);
    write_reg(REG_STEP_LIMIT, 1);
    write_reg(REG_START_HEAD, TAPE_CELLS - 1);
    apb_release();
    send_load(START_STATE, 4'd0, 1'b1, 4'd9, MOVE_RIGHT, 5'd3);
    send_op(OP_START);
    send_op(OP_STEP);

    // A final state entered by the step that also reaches the limit.
    send_load(START_STATE, 4'd0, 1'b1, 4'd0, MOVE_STAY, 5'd3);
    send_op(OP_START);
    send_op(OP_STEP);

    // A run whose limit is lowered below its count while it is still going.
    drain();
    write_reg(REG_FINAL_MASK, '0);
    write_reg(REG_STEP_LIMIT, 3);
    apb_release();
    send_load(START_STATE, 4'd0, 1'b1, 4'd0, MOVE_STAY, START_STATE);
    send_op(OP_START);
    send_op(OP_STEP);
    send_op(OP_STEP);
    drain();
    write_reg(REG_STEP_LIMIT, 1);
    apb_release();
    send_op(OP_STEP);

    // Head at cell zero reading a symbol whose rule was cleared.
    drain();
    write_reg(REG_STEP_LIMIT, 65535);
    write_reg(REG_START_HEAD, 0);
    apb_release();
    send_load(START_STATE, 4'd5, 1'b0, 4'd2, MOVE_RIGHT, 5'd2);
    send_op(OP_START);
    send_op(OP_STEP);
  endtask

  // A small program over a few symbols and states, a seeded tape, then a run.
  task automatic run_program();
    logic [SYM_W-1:0]   alpha [4];
    logic [STATE_W-1:0] prog_states [5];
    logic [SYM_W-1:0]   ws;
    logic [STATE_W-1:0] nx;
    int                 n_alpha;
    int                 n_states;
    int                 n_cells;
    int                 n_steps;
    int                 pick;
    n_alpha = $urandom_range(4, 2);
    n_states = $urandom_range(5, 2);
    foreach (alpha[i]) alpha[i] = SYM_W'($urandom_range(SYMBOL_COUNT - 1));
    if ($urandom_range(99) < 80) alpha[0] = BLANK_SYM;
    prog_states[0] = START_STATE;
    for (int i = 1; i < 5; i++) prog_states[i] = STATE_W'($urandom_range(STATE_COUNT - 1));

    // Rules, with a few holes and a few jumps outside the program.
    for (int i = 0; i < n_states; i++) begin
      for (int j = 0; j < n_alpha; j++) begin
        if ($urandom_range(99) < 85) begin
          ws = alpha[$urandom_range(n_alpha - 1)];
          if ($urandom_range(9) == 0) ws = SYM_W'($urandom);
          nx = prog_states[$urandom_range(n_states - 1)];
          if ($urandom_range(9) == 0) nx = STATE_W'($urandom);
          send_load(prog_states[i], alpha[j], 1'b1, ws, pick_move(), nx);
        end else begin
          send_load(prog_states[i], alpha[j], 1'b0, SYM_W'($urandom), MOVE_W'($urandom),
                    STATE_W'($urandom));
        end
      end
    end

    // Seed the tape around the start cell.
    n_cells = $urandom_range(6);
    for (int i = 0; i < n_cells; i++) begin
      send_write(near_cell(int'(mirror.start_head)), alpha[$urandom_range(n_alpha - 1)]);
    end

    // Run, with an occasional read, stray command or restart mixed in.
    send_op(OP_START);
    n_steps = $urandom_range(40, 4);
    for (int i = 0; i < n_steps; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_read(near_cell(int'(mirror.head)));
      end else if (pick < 10) begin
        send(random_cmd());
      end else if (pick < 12) begin
        send_op(OP_START);
      end else begin
        send_op(OP_STEP);
      end
    end
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(30, 10);
    for (int i = 0; i < n; i++) send(random_cmd());
  endtask

  // Steps that carry on an earlier run, often after the limit has changed.
  task automatic resume_run();
    int n;
    n = $urandom_range(20, 5);
    for (int i = 0; i < n; i++) send_op(OP_STEP);
  endtask

  task automatic random_part();
    int progress;
    int phase_no;
    phase_no = 0;
    random_base = sent;
    while (sent - random_base < RANDOM_ITEMS) begin
      progress = sent - random_base;
      if (progress < RANDOM_ITEMS / 3) begin
        src_idle_pct = 22;
        rcv_idle_pct = 88;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 88;
        rcv_idle_pct = 22;
      end else begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if ($urandom_range(99) < 60) reconfigure();
      // Long receiver hold-off while commands keep coming.
      if (phase_no == 4) hold_req = 1'b1;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: run_program();
        7, 8: noise_burst();
        default: resume_run();
      endcase
      phase_no++;
    end
  endtask

  // Response side: take transactions, check them, and stall at random.
  initial begin
    machine_rsp_t got;
    int           hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.status = rsp_if.status;
        got.machine_state = rsp_if.machine_state;
        got.head_position = rsp_if.head_position;
        got.cell_symbol = rsp_if.cell_symbol;
        got.steps_taken = rsp_if.steps_taken;
        mirror.compare_response(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Command side and the end of the run.
  initial begin
    mirror = new();
    sent = 0;
    reg_writes = 0;
    random_base = 0;
    hold_req = 1'b0;
    src_idle_pct = 22;
    rcv_idle_pct = 88;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = OP_LOAD_RULE;
    cmd_if.rule_state = '0;
    cmd_if.symbol = '0;
    cmd_if.rule_defined = 1'b0;
    cmd_if.rule_write_symbol = '0;
    cmd_if.rule_move = MOVE_STAY;
    cmd_if.rule_next_state = '0;
    cmd_if.tape_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    random_part();

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d commands: %0d rule loads, %0d starts, %0d steps, %0d register writes.",
             sent, mirror.loads, mirror.starts, mirror.step_cmds, reg_writes);
    $display("Steps ended with %0d running, %0d final, %0d no rule, %0d limit, %0d off tape.",
             mirror.step_outcome[STS_OK], mirror.step_outcome[STS_FINAL],
             mirror.step_outcome[STS_NO_RULE], mirror.step_outcome[STS_LIMIT],
             mirror.step_outcome[STS_OFF_TAPE]);
    if (mirror.mismatches == 0) begin
      $display("[table_driven_turing_machine_top] OK");
    end else begin
      $display("[table_driven_turing_machine_top] ERROR");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #(LIMIT_NS);
    $display("[table_driven_turing_machine_top] ERROR");
    $finish;
  end

endmodule
